@@ rtl/ifd_pkg.sv @@
// shared types and constants for the interpolated feedback delay
// no dependencies; imported by the multiplier, the top level and the testbench
`timescale 1ns / 1ps

package ifd_pkg;

	// geometry of the delay lines (line depth must be a power of two)
	localparam int LINE_DEPTH = 65536;
	localparam int FRAC_BITS  = 8;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int POS_W      = ADDR_W + FRAC_BITS;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int DELAY_W  = 25;
	localparam int GAIN_SHIFT = 15;

	// datapath widths
	localparam int SUM_W   = SAMPLE_W + 2;
	localparam int MUL_A_W = SUM_W;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ENABLED = 2'd0,
		CFG_LEVEL   = 2'd1,
		CFG_DELAY   = 2'd2
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_MUL_L,
		ST_MUL_R,
		ST_FB_L,
		ST_FB_R,
		ST_WR_R,
		ST_OUT
	} state_t;

endpackage

@@ rtl/interpolated_feedback_delay_top.sv @@
// stereo fractional feedback delay with linear interpolation
// depends on ifd_pkg, ifd_ram (one per channel) and ifd_mul (shared multiplier)
// enabled, a word passes through RD_A, RD_B, MUL_L, MUL_R, FB_L, FB_R, WR_R and OUT, and its result is loaded in OUT
// one word at a time: a new word is accepted only in the idle state; enabled, the single multiplier does four
//   products per word and each line memory has a single read port
// reset: arst_n resets control, configuration registers and write pointer; line contents are not swept,
//   a fill mark (write pointer plus wrapped flag) makes never-written entries read as zero
`timescale 1ns / 1ps

module interpolated_feedback_delay_top
	import ifd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [DELAY_W-1:0]         cfg_data,
	// input sample words
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] left_in,
	input  logic signed [SAMPLE_W-1:0] right_in,
	// output sample words
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out
);

	// saturate a wide signed value to the sample range
	function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [PROD_W-1:0] v);
		logic [SAMPLE_W-1:0] res;
		// fits when all bits above the sample msb match the sign
		if (v[PROD_W-1:SAMPLE_W-1] == '0 || v[PROD_W-1:SAMPLE_W-1] == '1) begin
			res = v[SAMPLE_W-1:0];
		end else if (v[PROD_W-1]) begin
			res = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return res;
	endfunction

	// configuration registers
	logic               enabled_q;
	logic [GAIN_W-1:0]  level_gain_q;
	logic [DELAY_W-1:0] delay_amount_q;

	// sequencer
	state_t state_q, state_d;

	// write pointer and fill mark
	logic [ADDR_W-1:0] wi_q;
	logic              wrapped_q;

	// per-word working registers
	logic                       en_q;
	logic signed [SAMPLE_W-1:0] x_l_q, x_r_q;
	logic [ADDR_W-1:0]          base_q;
	logic [FRAC_BITS-1:0]       frac_q;
	logic signed [SAMPLE_W-1:0] a_l_q, a_r_q, b_r_q;
	logic signed [SUM_W-1:0]    sum_l_q, sum_r_q;

	// output register
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        left_out_q, right_out_q;

	// datapath nets
	logic [POS_W-1:0]           delay_sat;
	logic [POS_W-1:0]           rpos;
	logic [ADDR_W-1:0]          next_addr;
	logic                       base_ok, next_ok;
	logic [ADDR_W-1:0]          raddr;
	logic [SAMPLE_W-1:0]        rdata_l, rdata_r;
	logic signed [SAMPLE_W-1:0] rd_l, rd_r;
	logic signed [SUM_W-1:0]    diff_l, diff_r;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   interp;
	logic [SAMPLE_W-1:0]        fb_word;
	logic                       we_l, we_r;
	logic                       in_fire, out_free, out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// configuration writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			level_gain_q   <= '0;
			delay_amount_q <= DELAY_W'(LINE_DEPTH) << FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLED: enabled_q      <= cfg_data[0];
				CFG_LEVEL:   level_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_DELAY:   delay_amount_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// read position: a delay of a full line or more lands on the write pointer itself,
	// and the line length is a power of two so wrapping is plain truncation
	assign delay_sat = (delay_amount_q >= (DELAY_W'(LINE_DEPTH) << FRAC_BITS))
		? '0 : delay_amount_q[POS_W-1:0];
	assign rpos      = {wi_q, {FRAC_BITS{1'b0}}} - delay_sat;
	assign next_addr = base_q + 1'b1;

	// entries not yet written since reset read as zero
	assign base_ok = wrapped_q || (base_q < wi_q);
	assign next_ok = wrapped_q || (next_addr < wi_q);
	assign rd_l    = signed'(rdata_l);
	assign rd_r    = signed'(rdata_r);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire) state_d = enabled_q ? ST_RD_A : ST_OUT;
			ST_RD_A:  state_d = ST_RD_B;
			ST_RD_B:  state_d = ST_MUL_L;
			ST_MUL_L: state_d = ST_MUL_R;
			ST_MUL_R: state_d = ST_FB_L;
			ST_FB_L:  state_d = ST_FB_R;
			ST_FB_R:  state_d = ST_WR_R;
			ST_WR_R:  state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: memory address, multiplier operands, write strobes, output load
	assign diff_l  = SUM_W'(rd_l) - SUM_W'(a_l_q);
	assign diff_r  = SUM_W'(b_r_q) - SUM_W'(a_r_q);
	assign fb_word = sat_sample(prod >>> GAIN_SHIFT);

	always_comb begin
		raddr    = base_q;
		mul_a    = '0;
		mul_b    = '0;
		we_l     = 1'b0;
		we_r     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_RD_A:  raddr = base_q;
			ST_RD_B:  raddr = next_addr;
			ST_MUL_L: begin
				// left interpolation step, b masked by fill mark
				mul_a = next_ok ? diff_l : (SUM_W'(0) - SUM_W'(a_l_q));
				mul_b = MUL_B_W'(frac_q);
			end
			ST_MUL_R: begin
				mul_a = diff_r;
				mul_b = MUL_B_W'(frac_q);
			end
			ST_FB_L: begin
				mul_a = sum_l_q;
				mul_b = MUL_B_W'(level_gain_q);
			end
			ST_FB_R: begin
				mul_a = sum_r_q;
				mul_b = MUL_B_W'(level_gain_q);
				we_l  = 1'b1;
			end
			ST_WR_R:  we_r = 1'b1;
			ST_OUT:   out_load = out_free;
			default:  ;
		endcase
	end

	// shared multiplier, product registered in the cycle after the operands
	ifd_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// floored interpolation term of whichever channel the multiplier just finished
	assign interp = prod >>> FRAC_BITS;

	// one line memory per channel, both written at the write pointer
	ifd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_l (
		.clk   (clk),
		.we    (we_l),
		.waddr (wi_q),
		.wdata (fb_word),
		.raddr (raddr),
		.rdata (rdata_l)
	);

	ifd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_r (
		.clk   (clk),
		.we    (we_r),
		.waddr (wi_q),
		.wdata (fb_word),
		.raddr (raddr),
		.rdata (rdata_r)
	);

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_l_q  <= left_in;
			x_r_q  <= right_in;
			base_q <= rpos[POS_W-1:FRAC_BITS];
			frac_q <= rpos[FRAC_BITS-1:0];
		end
		if (state_q == ST_RD_B) begin
			a_l_q <= base_ok ? rd_l : '0;
			a_r_q <= base_ok ? rd_r : '0;
		end
		if (state_q == ST_MUL_L) begin
			b_r_q <= next_ok ? rd_r : '0;
		end
		if (state_q == ST_MUL_R) begin
			sum_l_q <= SUM_W'(x_l_q) + SUM_W'(a_l_q) + SUM_W'(interp);
		end
		if (state_q == ST_FB_L) begin
			sum_r_q <= SUM_W'(x_r_q) + SUM_W'(a_r_q) + SUM_W'(interp);
		end
		if (out_load) begin
			left_out_q  <= en_q ? sat_sample(PROD_W'(sum_l_q)) : x_l_q;
			right_out_q <= en_q ? sat_sample(PROD_W'(sum_r_q)) : x_r_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			en_q        <= 1'b0;
			wi_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				en_q <= enabled_q;
			end
			// pointer advances only for words that went through the lines
			if (out_load && en_q) begin
				wi_q <= wi_q + 1'b1;
				if (wi_q == ADDR_W'(LINE_DEPTH - 1)) begin
					wrapped_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = signed'(left_out_q);
	assign right_out = signed'(right_out_q);

	// no line write while waiting for a word
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!we_l && !we_r))
		else $error("line write outside of word processing");

	// write pointer moves only when an enabled word's result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wi_q) |-> $past(out_load && en_q))
		else $error("write pointer moved without a delayed word");

	// fill mark is sticky once the lines have wrapped
	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wrapped_q))
		else $error("fill mark dropped");

	// right line is written in the cycle after the left line
	assert property (@(posedge clk) disable iff (!arst_n)
		we_l |=> we_r)
		else $error("right line write missing after left");

endmodule

@@ rtl/ifd_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module ifd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ifd_mul.sv @@
// shared signed multiplier with registered product
// depends on ifd_pkg for operand widths
`timescale 1ns / 1ps

module ifd_mul
	import ifd_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] op_a,
	input  logic signed [MUL_B_W-1:0] op_b,
	output logic signed [PROD_W-1:0]  prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for the stereo interpolated feedback delay
// depends on ifd_pkg and interpolated_feedback_delay_top; predicts every output word in a
// scoreboard class, writes config and drives input and output channels with random idling
`timescale 1ns / 1ps

module tb_top
	import ifd_pkg::*;
();

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one stereo output word
	typedef struct {
		sample_t left;
		sample_t right;
	} stereo_t;

	localparam int WORD_TARGET = 1950;
	localparam int CALM_WORDS  = 150;     // final stretch with no idling
	localparam int HOLD_CYCLES = 400;     // long receiver hold-off
	localparam int SETTLE      = 10;      // settling wait at the end of drain
	localparam int CYCLE_LIMIT = 600000;

	// predicts the delay lines and checks output words in order
	class echo_scoreboard;
		bit signed [SAMPLE_W-1:0] left_line  [LINE_DEPTH];
		bit signed [SAMPLE_W-1:0] right_line [LINE_DEPTH];
		int unsigned      write_ptr;
		bit               enabled;
		bit [GAIN_W-1:0]  level;
		bit [DELAY_W-1:0] delay;
		stereo_t          expected_mix [$];
		int               errors;
		int               checked;

		function new();
			write_ptr = 0;
			enabled   = 1'b0;
			level     = '0;
			delay     = 25'h1000000;
			errors    = 0;
			checked   = 0;
		endfunction

		function void note_config(cfg_idx_t idx, logic [DELAY_W-1:0] data);
			case (idx)
				CFG_ENABLED: enabled = data[0];
				CFG_LEVEL:   level   = data[GAIN_W-1:0];
				CFG_DELAY:   delay   = data;
				default:     ;
			endcase
		endfunction

		function sample_t clip16(longint v);
			if (v > 32767) return 16'sd32767;
			if (v < -32768) return -16'sd32768;
			return sample_t'(v);
		endfunction

		// interpolated tap, sum, feedback write for one channel
		function sample_t mix_channel(bit right_side, sample_t x, int unsigned base,
				int unsigned nxt, int unsigned frac);
			longint a, b, tap, sum, fb;
			a = right_side ? right_line[base] : left_line[base];
			b = right_side ? right_line[nxt] : left_line[nxt];
			tap = a + (((b - a) * longint'(frac)) >>> FRAC_BITS);
			sum = longint'(x) + tap;
			fb = (sum * longint'(level)) >>> GAIN_SHIFT;
			if (right_side)
				right_line[write_ptr] = clip16(fb);
			else
				left_line[write_ptr] = clip16(fb);
			return clip16(sum);
		endfunction

		function stereo_t predict_echo(sample_t l, sample_t r);
			stereo_t res;
			longint unsigned full_pos, d, rpos;
			int unsigned base, nxt, frac;
			res.left  = l;
			res.right = r;
			if (!enabled)
				return res;
			full_pos = longint'(LINE_DEPTH) << FRAC_BITS;
			d = (delay > full_pos) ? full_pos : longint'(delay);
			rpos = (longint'(write_ptr) << FRAC_BITS) + full_pos - d;
			if (rpos >= full_pos)
				rpos -= full_pos;
			base = int'(rpos >> FRAC_BITS);
			frac = int'(rpos & ((64'd1 << FRAC_BITS) - 1));
			nxt  = (base + 1) % LINE_DEPTH;
			res.left  = mix_channel(1'b0, l, base, nxt, frac);
			res.right = mix_channel(1'b1, r, base, nxt, frac);
			write_ptr = (write_ptr + 1) % LINE_DEPTH;
			return res;
		endfunction

		function void note_word(sample_t l, sample_t r);
			expected_mix.push_back(predict_echo(l, r));
		endfunction

		function void check_word(sample_t l, sample_t r);
			stereo_t exp_w;
			if (expected_mix.size() == 0) begin
				$error("unexpected word: left_out %0d right_out %0d", l, r);
				errors++;
				return;
			end
			exp_w = expected_mix.pop_front();
			checked++;
			if (l !== exp_w.left) begin
				$error("left_out: expected %0d, got %0d", exp_w.left, l);
				errors++;
			end
			if (r !== exp_w.right) begin
				$error("right_out: expected %0d, got %0d", exp_w.right, r);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [DELAY_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              left_in;
	sample_t              right_in;
	logic                 out_valid;
	logic                 out_ready;
	sample_t              left_out;
	sample_t              right_out;

	echo_scoreboard sb = new();

	int  words_sent;
	int  reg_writes;
	int  phases;
	int  cycle_count;
	bit  calm;       // no idling on either side
	bit  hold_req;   // asks the receiver for one long hold-off

	interpolated_feedback_delay_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// monitor: every handshake is seen at the edge where it happens
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.note_config(cfg_idx_t'(cfg_index), cfg_data);
				reg_writes++;
			end
			if (in_valid && in_ready)
				sb.note_word(left_in, right_in);
			if (out_valid && out_ready)
				sb.check_word(left_out, right_out);
		end
	end

	// receiver: random stall bursts, one long hold-off on request, none when calm
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				// long hold so the block fills up and backs up the input
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(cfg_idx_t idx, logic [DELAY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(bit en, bit [GAIN_W-1:0] gain, bit [DELAY_W-1:0] dly);
		write_reg(CFG_ENABLED, DELAY_W'(en));
		write_reg(CFG_LEVEL, DELAY_W'(gain));
		write_reg(CFG_DELAY, dly);
		cfg_valid <= 1'b0;
	endtask

	// offer one word, possibly after a random gap; returns at the accepting edge
	task automatic send_word(sample_t l, sample_t r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in  <= l;
		right_in <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// stop offering and wait for every result, then let the write-back settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.checked < words_sent)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'sd32767;
			1:       return -16'sd32768;
			2:       return sample_t'(int'($urandom_range(0, 2000)) - 1000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin : stimulus
		int n;
		bit en;
		bit [GAIN_W-1:0] gain;
		bit [DELAY_W-1:0] dly;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ENABLED;
		cfg_data  = '0;
		in_valid  = 1'b0;
		left_in   = '0;
		right_in  = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		words_sent = 0;
		reg_writes = 0;
		phases     = 0;
		cycle_count = 0;

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: disabled, words pass straight through
		send_word(16'sd32767, -16'sd32768);
		send_word(-16'sd32768, 16'sd32767);
		send_word(16'sd0, -16'sd1);
		drain();

		// gain one, one sample back: saturation on the sum and on the feedback
		configure(1'b1, 16'd32768, 25'd256);
		send_word(16'sd32767, -16'sd32768);
		send_word(16'sd32767, -16'sd32768);
		send_word(16'sd1000, -16'sd1000);
		send_word(-16'sd1, 16'sd1);
		drain();

		// gain above one, 1.5 samples back: fractional tap, floor on negative slopes
		configure(1'b1, 16'hFFFF, 25'd384);
		send_word(16'sd12345, -16'sd777);
		send_word(-16'sd3, 16'sd5);
		send_word(16'sd20000, -16'sd20000);
		send_word(-16'sd7, 16'sd9);
		drain();

		// zero delay: tap sits on the entry about to be written; zero feedback
		configure(1'b1, 16'd0, 25'd0);
		send_word(16'sd100, -16'sd100);
		send_word(-16'sd32768, 16'sd32767);
		drain();

		// full-line delay, then a delay beyond the line that clamps to it
		configure(1'b1, 16'd16384, 25'h1000000);
		send_word(16'sd500, -16'sd500);
		send_word(16'sd32767, -16'sd32768);
		drain();
		configure(1'b1, 16'd32768, 25'h1FFFFFF);
		send_word(-16'sd2, 16'sd2);
		send_word(16'sd4321, -16'sd4321);
		drain();

		// disabled keeps the lines; re-enabling reads back what was written before
		configure(1'b0, 16'd12345, 25'd640);
		send_word(16'sd111, -16'sd222);
		send_word(-16'sd32768, 16'sd32767);
		drain();
		configure(1'b1, 16'd32768, 25'd640);
		send_word(16'sd0, 16'sd0);
		send_word(16'sd300, -16'sd300);
		send_word(-16'sd1, -16'sd1);
		drain();

		// random phases, each with its own register setting
		while (words_sent < WORD_TARGET) begin
			phases++;
			calm = (words_sent >= WORD_TARGET - CALM_WORDS);
			n = $urandom_range(20, 120);
			en = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 5))
				0:       gain = 16'd0;
				1:       gain = 16'd32768;
				2:       gain = 16'hFFFF;
				3:       gain = GAIN_W'($urandom_range(32769, 65535));
				default: gain = GAIN_W'($urandom_range(0, 32768));
			endcase
			case ($urandom_range(0, 9))
				0:       dly = 25'd0;
				1:       dly = 25'h1000000;
				2:       dly = DELAY_W'($urandom_range(25'h1000001, 25'h1FFFFFF));
				3:       dly = DELAY_W'(25'h1000000 - $urandom_range(0, 4096));
				4:       dly = DELAY_W'($urandom_range(0, 25'h1FFFFFF));
				// in half of the cases short delays so the taps land on entries already written
				default: dly = DELAY_W'($urandom_range(0, 96 * 256));
			endcase
			drain();
			configure(en, gain, dly);
			if (phases == 3)
				hold_req = 1'b1;
			for (int i = 0; i < n; i++) begin
				// once, the sender stops mid-phase until the block is empty
				if (phases == 5 && i == n / 2)
					drain();
				send_word(pick_sample(), pick_sample());
			end
		end

		drain();
		repeat (20)
			@(posedge clk);

		$display("tb_top: %0d words in %0d random phases plus directed cases, %0d checked",
			words_sent, phases, sb.checked);
		$display("tb_top: %0d register writes, %0d mismatches", reg_writes, sb.errors);
		if (sb.errors == 0 && sb.expected_mix.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
